>>> hdl/tgt_pkg.sv
// ============================================================================
// Twiddle gain tuner package
// Shared widths, function codes, register indexes, scale constants and the
// divider interface types.
// ============================================================================
package tgt_pkg;

    // Field and state widths
    localparam int GAIN_W  = 32;
    localparam int DELTA_W = 31;
    localparam int ERR_W   = 48;
    localparam int CTE_W   = 16;
    localparam int STEPS_W = 16;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 32;
    localparam int COEF_W  = 17;
    localparam int PROD_W  = DELTA_W + COEF_W;

    // Request function codes
    typedef enum logic [1:0] {
        FUNC_ERR     = 2'd0,
        FUNC_BEST    = 2'd1,
        FUNC_TUNE    = 2'd2,
        FUNC_RESTART = 2'd3
    } t_func;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_GAIN_P  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_GAIN_I  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_GAIN_D  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_DELTA_P = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_DELTA_I = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_DELTA_D = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_THRESH  = 3'd6;

    // Q16.16 constants
    localparam logic [DELTA_W-1:0] ONE_Q16    = 31'd65536;
    localparam logic [DELTA_W-1:0] THR_RESET  = 31'd131;
    localparam logic [COEF_W-1:0]  GROW_Q16   = 17'd72090;
    localparam logic [COEF_W-1:0]  SHRINK_Q16 = 17'd58982;
    localparam logic [DELTA_W-1:0] DELTA_MAX  = 31'h7FFF_FFFF;
    localparam logic [ERR_W-1:0]   ERR_MAX    = 48'hFFFF_FFFF_FFFF;

    // Divider request and response
    typedef struct packed {
        logic               start;
        logic [ERR_W-1:0]   dividend;
        logic [STEPS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [ERR_W-1:0] quot;
    } t_div_rsp;

endpackage

>>> hdl/tgt_div.sv
// ============================================================================
// Twiddle gain tuner divider
// Restoring unsigned divider, one quotient bit per cycle, for the average
// error (error sum over step count).
// ============================================================================
module tgt_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tgt_pkg::t_div_req i_req,
    output tgt_pkg::t_div_rsp o_rsp
);
    import tgt_pkg::*;

    localparam int CNT_W = $clog2(ERR_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [STEPS_W-1:0]   r_rem;
    logic [STEPS_W-1:0]   r_divisor;
    logic [ERR_W-1:0]     r_quo;
    logic [STEPS_W:0]     w_rem_sh;
    logic [STEPS_W:0]     w_diff;
    logic                 w_ge;

    // Shift in the next dividend bit and trial-subtract
    assign w_rem_sh = {r_rem, r_quo[ERR_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_divisor};
    assign w_diff   = w_rem_sh - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ERR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo     <= i_req.dividend;
            r_rem     <= '0;
            r_divisor <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[ERR_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[STEPS_W-1:0] : w_rem_sh[STEPS_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

>>> hdl/twiddle_gain_tuner_unit.sv
// ============================================================================
// Twiddle gain tuner
// Coordinate-ascent tuner for a set of Q16.16 PID gains, driven by requests.
// ============================================================================
// One request is taken at a time and each gives exactly one result. An error
// sample passes through acceptance, a square on the shared multiplier, a
// saturating accumulate and the output load; a restart goes from acceptance
// straight to the output load. Setting the best error runs the restoring
// divider when the step count is nonzero and loads zero otherwise. A tuning
// step first sums the deltas of all gains, then may run the divider, which
// forms the average error, before it steps a gain. The next request
// is taken while a finished result still waits on the output register.
module twiddle_gain_tuner_unit #(
    parameter int NUM_GAINS = 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration writes
    input  logic                       i_cfg_we,
    input  logic [tgt_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [tgt_pkg::CFG_DW-1:0] i_cfg_wdata,
    // Request stream
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [31:0]                s_axis_tdata,  // cte[15:0], steps[31:16]
    input  logic [2:0]                 s_axis_tuser,  // func[1:0], complete[2]
    // Result stream
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // gain_p[31:0], gain_i[63:32], gain_d[95:64], best_p[127:96],
    // best_i[159:128], best_d[191:160], tune_index[193:192], zero[199:194]
    output logic [199:0]               m_axis_tdata,
    output logic                       m_axis_tuser   // done_res[0]
);
    import tgt_pkg::*;

    localparam int IDX_W  = (NUM_GAINS > 1) ? $clog2(NUM_GAINS) : 1;
    localparam int DSUM_W = DELTA_W + ((NUM_GAINS > 1) ? $clog2(NUM_GAINS) : 0);
    localparam int SUM_W  = GAIN_W + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ACC, S_DIV, S_SUM, S_CHK,
        S_TUNE, S_MISS, S_SCALE, S_ADV, S_ADD, S_FIN
    } t_state;

    // Configuration registers
    logic signed [GAIN_W-1:0]  r_cfg_gain  [3];
    logic        [DELTA_W-1:0] r_cfg_delta [3];
    logic        [DELTA_W-1:0] r_cfg_thr;

    // Tuner state
    t_state                    r_state;
    logic signed [GAIN_W-1:0]  r_gain  [NUM_GAINS];
    logic        [DELTA_W-1:0] r_delta [NUM_GAINS];
    logic signed [GAIN_W-1:0]  r_best  [NUM_GAINS];
    logic        [ERR_W-1:0]   r_err;
    logic        [ERR_W-1:0]   r_best_avg;
    logic        [IDX_W-1:0]   r_idx;
    logic        [IDX_W-1:0]   r_ptr;
    logic                      r_add_flag;
    logic                      r_sub_flag;
    logic        [DSUM_W-1:0]  r_dsum;
    logic                      r_done;

    // Latched request
    t_func                     r_func;
    logic        [STEPS_W-1:0] r_steps;
    logic                      r_complete;

    // Shared multiplier
    logic        [DELTA_W-1:0] r_ma;
    logic        [COEF_W-1:0]  r_mb;
    logic        [PROD_W-1:0]  r_prod;

    // Divider
    logic                      r_div_start;
    t_div_req                  w_div_req;
    t_div_rsp                  w_div_rsp;

    // Output register
    logic                      r_ovalid;
    logic                      r_o_done;
    logic signed [GAIN_W-1:0]  r_o_gain [3];
    logic signed [GAIN_W-1:0]  r_o_best [3];
    logic        [1:0]         r_o_idx;

    // Combinational helpers
    t_func                     w_func;
    logic signed [CTE_W-1:0]   w_cte;
    logic        [CTE_W-1:0]   w_cte_abs;
    logic                      w_accept;
    logic signed [GAIN_W-1:0]  w_gain_rd;
    logic        [DELTA_W-1:0] w_delta_rd;
    logic signed [SUM_W-1:0]   w_addend;
    logic signed [SUM_W-1:0]   w_gsum;
    logic signed [GAIN_W-1:0]  w_gsat;
    logic        [ERR_W:0]     w_err_sum;
    logic        [ERR_W-1:0]   w_err_sat;
    logic        [PROD_W:0]    w_round;
    logic        [PROD_W-16:0] w_scaled;
    logic        [DELTA_W-1:0] w_delta_sat;
    logic                      w_load;
    logic signed [GAIN_W-1:0]  w_rl_gain  [NUM_GAINS];
    logic        [DELTA_W-1:0] w_rl_delta [NUM_GAINS];
    logic signed [GAIN_W-1:0]  w_out_gain [3];
    logic signed [GAIN_W-1:0]  w_out_best [3];

    assign w_func    = t_func'(s_axis_tuser[1:0]);
    assign w_cte     = s_axis_tdata[CTE_W-1:0];
    assign w_cte_abs = w_cte[CTE_W-1] ? CTE_W'(-w_cte) : CTE_W'(w_cte);
    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_cfg_gain[k]  <= '0;
                r_cfg_delta[k] <= ONE_Q16;
            end
            r_cfg_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_GAIN_P:  r_cfg_gain[0]  <= i_cfg_wdata;
                CFG_GAIN_I:  r_cfg_gain[1]  <= i_cfg_wdata;
                CFG_GAIN_D:  r_cfg_gain[2]  <= i_cfg_wdata;
                CFG_DELTA_P: r_cfg_delta[0] <= i_cfg_wdata[DELTA_W-1:0];
                CFG_DELTA_I: r_cfg_delta[1] <= i_cfg_wdata[DELTA_W-1:0];
                CFG_DELTA_D: r_cfg_delta[2] <= i_cfg_wdata[DELTA_W-1:0];
                CFG_THRESH:  r_cfg_thr      <= i_cfg_wdata[DELTA_W-1:0];
                default: ;
            endcase
        end
    end

    // Restart values and output field mapping per gain slot
    for (genvar k = 0; k < NUM_GAINS; k++) begin : g_reload
        if (k < 3) begin : g_cfg
            assign w_rl_gain[k]  = r_cfg_gain[k];
            assign w_rl_delta[k] = r_cfg_delta[k];
        end else begin : g_def
            assign w_rl_gain[k]  = '0;
            assign w_rl_delta[k] = ONE_Q16;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_out
        if (k < NUM_GAINS) begin : g_used
            assign w_out_gain[k] = r_gain[k];
            assign w_out_best[k] = r_best[k];
        end else begin : g_absent
            assign w_out_gain[k] = '0;
            assign w_out_best[k] = '0;
        end
    end

    // Single read port at the sequencer pointer
    assign w_gain_rd  = r_gain[r_ptr];
    assign w_delta_rd = r_delta[r_ptr];

    // Shared saturating gain adder: add delta, or subtract twice the delta
    always_comb begin
        if (r_state == S_MISS && !r_sub_flag) begin
            w_addend = -$signed({2'b00, w_delta_rd, 1'b0});
        end else begin
            w_addend = $signed({3'b000, w_delta_rd});
        end
        w_gsum = SUM_W'(w_gain_rd) + w_addend;
        if (w_gsum[SUM_W-1:GAIN_W-1] == '0 || w_gsum[SUM_W-1:GAIN_W-1] == '1) begin
            w_gsat = w_gsum[GAIN_W-1:0];
        end else if (w_gsum[SUM_W-1]) begin
            w_gsat = {1'b1, {(GAIN_W-1){1'b0}}};
        end else begin
            w_gsat = {1'b0, {(GAIN_W-1){1'b1}}};
        end
    end

    // Saturating error accumulate
    assign w_err_sum = {1'b0, r_err} + (ERR_W+1)'(r_prod);
    assign w_err_sat = w_err_sum[ERR_W] ? ERR_MAX : w_err_sum[ERR_W-1:0];

    // Delta scale: round half up, saturate
    assign w_round     = {1'b0, r_prod} + (PROD_W+1)'(32768);
    assign w_scaled    = w_round[PROD_W:16];
    assign w_delta_sat = (w_scaled > (PROD_W-15)'(DELTA_MAX)) ? DELTA_MAX
                                                              : w_scaled[DELTA_W-1:0];

    // Divider
    assign w_div_req.start    = r_div_start;
    assign w_div_req.dividend = r_err;
    assign w_div_req.divisor  = r_steps;

    tgt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_load = (r_state == S_FIN) && (!r_ovalid || m_axis_tready);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_err       <= '0;
            r_best_avg  <= '0;
            r_idx       <= '0;
            r_ptr       <= '0;
            r_add_flag  <= 1'b0;
            r_sub_flag  <= 1'b0;
            r_div_start <= 1'b0;
            r_done      <= 1'b0;
            r_ovalid    <= 1'b0;
            for (int k = 0; k < NUM_GAINS; k++) begin
                r_gain[k]  <= '0;
                r_delta[k] <= ONE_Q16;
                r_best[k]  <= '0;
            end
        end else begin
            r_div_start <= 1'b0;

            // Drop the result once taken
            if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_func     <= w_func;
                        r_steps    <= s_axis_tdata[31:16];
                        r_complete <= s_axis_tuser[2];
                        r_done     <= 1'b0;
                        unique case (w_func)
                            FUNC_ERR: begin
                                r_ma    <= DELTA_W'(w_cte_abs);
                                r_mb    <= COEF_W'(w_cte_abs);
                                r_state <= S_MUL;
                            end
                            FUNC_BEST: begin
                                if (s_axis_tdata[31:16] == '0) begin
                                    r_best_avg <= '0;
                                    r_state    <= S_FIN;
                                end else begin
                                    r_div_start <= 1'b1;
                                    r_state     <= S_DIV;
                                end
                            end
                            FUNC_TUNE: begin
                                r_ptr   <= '0;
                                r_dsum  <= '0;
                                r_state <= S_SUM;
                            end
                            FUNC_RESTART: begin
                                for (int k = 0; k < NUM_GAINS; k++) begin
                                    r_gain[k]  <= w_rl_gain[k];
                                    r_delta[k] <= w_rl_delta[k];
                                end
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_prod  <= r_ma * r_mb;
                    r_state <= (r_func == FUNC_ERR) ? S_ACC : S_SCALE;
                end
                S_ACC: begin
                    r_err   <= w_err_sat;
                    r_state <= S_FIN;
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        if (r_func == FUNC_BEST) begin
                            r_best_avg <= w_div_rsp.quot;
                            r_state    <= S_FIN;
                        end else if (w_div_rsp.quot < r_best_avg) begin
                            // Better run: record it and grow the delta
                            r_best_avg <= w_div_rsp.quot;
                            r_best     <= r_gain;
                            r_add_flag <= 1'b0;
                            r_sub_flag <= 1'b0;
                            r_ma       <= w_delta_rd;
                            r_mb       <= GROW_Q16;
                            r_state    <= S_MUL;
                        end else begin
                            r_state <= S_MISS;
                        end
                    end
                end
                S_SUM: begin
                    r_dsum <= r_dsum + DSUM_W'(w_delta_rd);
                    if (r_ptr == IDX_W'(NUM_GAINS - 1)) begin
                        r_state <= S_CHK;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_CHK: begin
                    if (r_dsum < DSUM_W'(r_cfg_thr)) begin
                        r_done  <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_ptr   <= r_idx;
                        r_state <= S_TUNE;
                    end
                end
                S_TUNE: begin
                    priority if (!r_add_flag) begin
                        r_state <= S_ADD;
                    end else if (r_steps == '0 || !r_complete) begin
                        r_state <= S_MISS;
                    end else begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_MISS: begin
                    r_gain[r_ptr] <= w_gsat;
                    if (!r_sub_flag) begin
                        // Try the other side
                        r_err      <= '0;
                        r_sub_flag <= 1'b1;
                        r_state    <= S_FIN;
                    end else begin
                        // Restore the gain and shrink the delta
                        r_add_flag <= 1'b0;
                        r_sub_flag <= 1'b0;
                        r_ma       <= w_delta_rd;
                        r_mb       <= SHRINK_Q16;
                        r_state    <= S_MUL;
                    end
                end
                S_SCALE: begin
                    r_delta[r_ptr] <= w_delta_sat;
                    r_state        <= S_ADV;
                end
                S_ADV: begin
                    r_err <= '0;
                    if (r_idx == IDX_W'(NUM_GAINS - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_ptr   <= r_idx + 1'b1;
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_gain[r_ptr] <= w_gsat;
                    r_err         <= '0;
                    r_add_flag    <= 1'b1;
                    r_state       <= S_FIN;
                end
                S_FIN: begin
                    if (w_load) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_done <= r_done;
            r_o_gain <= w_out_gain;
            r_o_best <= w_out_best;
            r_o_idx  <= 2'(r_idx);
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_o_done;
    assign m_axis_tdata  = {6'd0, r_o_idx,
                            r_o_best[2], r_o_best[1], r_o_best[0],
                            r_o_gain[2], r_o_gain[1], r_o_gain[0]};

endmodule

>>> hdl/tgt_checker.sv
// ============================================================================
// Twiddle gain tuner port checker
// Port-level checks on the request and result streams, bound to the top.
// ============================================================================
module tgt_checker #(
    parameter int NUM_GAINS = 3
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [199:0] m_axis_tdata,
    input logic         m_axis_tuser
);
    import tgt_pkg::*;

    // Clear the result stream at reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Go busy after each request
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while previous one is in work");

    // Hold a stalled result
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Keep the tuning index inside the gain set when it has fewer than four gains
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (NUM_GAINS < 4) |->
            (m_axis_tdata[193:192] < 2'(NUM_GAINS)))
        else $error("tuning index out of range");

endmodule

bind twiddle_gain_tuner_unit tgt_checker #(
    .NUM_GAINS (NUM_GAINS)
) u_tgt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
